// File: rtl/core/gab_pkg.sv
// ----------------------------------------------------------------------------
// gab_pkg: shared types and constants of the glyph alpha blend unit
// Register codes, configuration bundle, the classified pair record and the result record.
// ----------------------------------------------------------------------------
package gab_pkg;

  localparam int MaxGlyphSize = 64;
  localparam int MaxFrameSize = 2048;
  localparam int QueueDepth   = 4;

  localparam int CfgColW   = 10;
  localparam int CfgRowW   = 11;
  localparam int CfgFrameW = 12;
  localparam int CfgGlyphW = 7;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 12;

  localparam int RowW   = 12;
  localparam int ColW   = 11;
  localparam int FSizeW = 13;
  localparam int WprW   = 12;
  localparam int AddrW  = 21;
  localparam int WordW  = 32;
  localparam int AlphaW = 8;

  localparam logic [7:0] ChromaFill = 8'h7F;
  localparam logic [7:0] AlphaFull  = 8'hFF;

  localparam logic [CfgFrameW-1:0] FrameWidthRst  = 12'd640;
  localparam logic [CfgFrameW-1:0] FrameHeightRst = 12'd480;
  localparam logic [CfgGlyphW-1:0] GlyphWidthRst  = 7'd16;
  localparam logic [CfgGlyphW-1:0] GlyphHeightRst = 7'd20;

  typedef enum logic [CfgIdxW-1:0] {
    RegColOrigin   = 3'd0,
    RegRowOrigin   = 3'd1,
    RegFrameWidth  = 3'd2,
    RegFrameHeight = 3'd3,
    RegGlyphWidth  = 3'd4,
    RegGlyphHeight = 3'd5
  } gab_reg_e;

  typedef struct packed {
    logic [CfgColW-1:0]   col_origin;
    logic [CfgRowW-1:0]   row_origin;
    logic [CfgGlyphW-1:0] glyph_width;
    logic [CfgGlyphW-1:0] glyph_height;
    logic [FSizeW-1:0]    frame_height;
    logic [WprW-1:0]      words_per_row;
  } gab_cfg_t;

  typedef struct packed {
    logic [RowW-1:0]   row;
    logic [ColW-1:0]   col;
    logic              in_frame;
    logic              tail;
    logic              done;
    logic [AlphaW-1:0] alpha_left;
    logic [AlphaW-1:0] alpha_right;
    logic [WordW-1:0]  background_word;
  } gab_item_t;

  typedef struct packed {
    logic [AddrW-1:0] word_address;
    logic [WordW-1:0] new_word;
    logic             write_enable;
    logic             glyph_done;
  } gab_result_t;

endpackage

// File: rtl/core/gab_front.sv
// ----------------------------------------------------------------------------
// gab_front: glyph walker and pair classifier
// Accepts pixel pairs, tracks glyph row and pair column, forms the frame
// position, clips it and pushes a classified record into the queue.
// ----------------------------------------------------------------------------
module gab_front #(
  parameter int MAX_GLYPH_SIZE = gab_pkg::MaxGlyphSize
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  gab_pkg::gab_cfg_t                cfg_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [gab_pkg::AlphaW-1:0]       alpha_left_i,
  input  logic [gab_pkg::AlphaW-1:0]       alpha_right_i,
  input  logic [gab_pkg::WordW-1:0]        background_word_i,
  output logic                             push_valid_o,
  input  logic                             push_ready_i,
  output gab_pkg::gab_item_t               push_item_o
);
  import gab_pkg::*;

  localparam int MaxPairs = (MAX_GLYPH_SIZE + 1) / 2;
  localparam int PairW    = (MaxPairs > 1) ? $clog2(MaxPairs) : 1;
  localparam int GRowW    = $clog2(MAX_GLYPH_SIZE);
  localparam int GSizeW   = ($clog2(MAX_GLYPH_SIZE + 1) > CfgGlyphW) ?
                            $clog2(MAX_GLYPH_SIZE + 1) : CfgGlyphW;
  localparam int CmpW     = GSizeW + 1;

  logic [PairW-1:0]  pair_column_q, pair_column_d;
  logic [GRowW-1:0]  glyph_row_q, glyph_row_d;
  logic [GSizeW-1:0] gw, gh, pairs, gw_raw, gh_raw;
  logic [CmpW-1:0]   pc_next, gr_next, tail_pos;
  logic              tail, last_pair, last_row, accept;
  logic [RowW-1:0]   row;
  logic [ColW-1:0]   col;

  assign gw_raw = GSizeW'(cfg_i.glyph_width);
  assign gh_raw = GSizeW'(cfg_i.glyph_height);

  always_comb begin
    priority if (gw_raw == '0) begin
      gw = GSizeW'(1);
    end else if (gw_raw > GSizeW'(MAX_GLYPH_SIZE)) begin
      gw = GSizeW'(MAX_GLYPH_SIZE);
    end else begin
      gw = gw_raw;
    end
    priority if (gh_raw == '0) begin
      gh = GSizeW'(1);
    end else if (gh_raw > GSizeW'(MAX_GLYPH_SIZE)) begin
      gh = GSizeW'(MAX_GLYPH_SIZE);
    end else begin
      gh = gh_raw;
    end
  end

  assign pairs     = GSizeW'((CmpW'(gw) + CmpW'(1)) >> 1);
  assign pc_next   = CmpW'(pair_column_q) + CmpW'(1);
  assign gr_next   = CmpW'(glyph_row_q) + CmpW'(1);
  assign tail_pos  = CmpW'({pair_column_q, 1'b1});
  assign tail      = tail_pos >= CmpW'(gw);
  assign last_pair = pc_next >= CmpW'(pairs);
  assign last_row  = gr_next >= CmpW'(gh);

  assign row = RowW'(cfg_i.row_origin) + RowW'(glyph_row_q);
  assign col = ColW'(cfg_i.col_origin) + ColW'(pair_column_q);

  assign in_ready_o   = push_ready_i;
  assign push_valid_o = in_valid_i;
  assign accept       = in_valid_i && push_ready_i;

  always_comb begin
    push_item_o.row             = row;
    push_item_o.col             = col;
    push_item_o.in_frame        = ({1'b0, row} < cfg_i.frame_height) &&
                                  ({1'b0, col} < cfg_i.words_per_row);
    push_item_o.tail            = tail;
    push_item_o.done            = last_pair && last_row;
    push_item_o.alpha_left      = alpha_left_i;
    push_item_o.alpha_right     = tail ? '0 : alpha_right_i;
    push_item_o.background_word = background_word_i;
  end

  always_comb begin
    pair_column_d = pair_column_q;
    glyph_row_d   = glyph_row_q;
    if (accept) begin
      if (last_pair) begin
        pair_column_d = '0;
        glyph_row_d   = last_row ? '0 : GRowW'(gr_next);
      end else begin
        pair_column_d = PairW'(pc_next);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pair_column_q <= '0;
      glyph_row_q   <= '0;
    end else begin
      pair_column_q <= pair_column_d;
      glyph_row_q   <= glyph_row_d;
    end
  end

endmodule

// File: rtl/core/gab_fifo.sv
// ----------------------------------------------------------------------------
// gab_fifo: classified pair queue
// Short register queue between walker and blender; full and empty by count.
// ----------------------------------------------------------------------------
module gab_fifo #(
  parameter int DEPTH = gab_pkg::QueueDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_valid_i,
  output logic               push_ready_o,
  input  gab_pkg::gab_item_t push_item_i,
  output logic               pop_valid_o,
  input  logic               pop_ready_i,
  output gab_pkg::gab_item_t pop_item_o
);
  import gab_pkg::*;

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  gab_item_t       mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push, pop;

  assign push_ready_o = count_q != CntW'(DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    unique case ({push, pop})
      2'b10:   count_d = count_q + CntW'(1);
      2'b01:   count_d = count_q - CntW'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("queue count beyond depth");

  a_count_up : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (count_q == $past(count_q) + CntW'(1)))
    else $error("queue count did not advance on push");

  a_ptr_track : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers differ while empty");

endmodule

// File: rtl/core/gab_back.sv
// ----------------------------------------------------------------------------
// gab_back: address and luma blend pipeline
// Stage one multiplies row by words per row and forms the blend products;
// stage two adds the column, divides by 255 and builds the output word.
// ----------------------------------------------------------------------------
module gab_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [gab_pkg::WprW-1:0]   words_per_row_i,
  input  logic                       pop_valid_i,
  output logic                       pop_ready_o,
  input  gab_pkg::gab_item_t         pop_item_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output gab_pkg::gab_result_t       result_o
);
  import gab_pkg::*;

  localparam int ProdW  = RowW + WprW;
  localparam int BlendW = 2 * AlphaW;

  function automatic logic [AlphaW-1:0] div255_add(input logic [AlphaW-1:0] a,
                                                   input logic [BlendW-1:0] p);
    logic [BlendW:0] t;
    t = {1'b0, p} + (BlendW+1)'(p >> 8) + (BlendW+1)'(1);
    return a + AlphaW'(t >> 8);
  endfunction

  logic              s1_valid_q, out_valid_q, en;
  gab_item_t         s1_item_q;
  logic [ProdW-1:0]  s1_prod_q;
  logic [BlendW-1:0] s1_lp_q, s1_rp_q;
  gab_result_t       out_q, out_d;
  logic [AlphaW-1:0] y0, y1;
  logic              nz;

  assign en          = !out_valid_q || out_ready_i;
  assign pop_ready_o = en;
  assign out_valid_o = out_valid_q;
  assign result_o    = out_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_item_q <= pop_item_i;
      s1_prod_q <= ProdW'(pop_item_i.row) * ProdW'(words_per_row_i);
      s1_lp_q   <= BlendW'(AlphaFull - pop_item_i.alpha_left) *
                   BlendW'(pop_item_i.background_word[15:8]);
      s1_rp_q   <= BlendW'(AlphaFull - pop_item_i.alpha_right) *
                   BlendW'(pop_item_i.background_word[31:24]);
    end
  end

  always_comb begin
    nz = (s1_item_q.alpha_left != '0) || (s1_item_q.alpha_right != '0);
    y0 = div255_add(s1_item_q.alpha_left, s1_lp_q);
    y1 = s1_item_q.tail ? s1_item_q.background_word[31:24]
                        : div255_add(s1_item_q.alpha_right, s1_rp_q);
    out_d.glyph_done   = s1_item_q.done;
    out_d.write_enable = s1_item_q.in_frame && nz;
    out_d.word_address = s1_item_q.in_frame ?
                         s1_prod_q[AddrW-1:0] + AddrW'(s1_item_q.col) : '0;
    out_d.new_word     = out_d.write_enable ?
                         {y1, ChromaFill, y0, ChromaFill} :
                         s1_item_q.background_word;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q  <= pop_valid_i;
      out_valid_q <= s1_valid_q;
    end
  end

  a_chroma_fill : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.write_enable) |->
      (out_q.new_word[23:16] == ChromaFill && out_q.new_word[7:0] == ChromaFill))
    else $error("written word lacks forced chroma");

  a_stage_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !en) |=> s1_valid_q)
    else $error("stage one lost an item under stall");

  a_stage_move : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && en) |=> out_valid_q)
    else $error("stage one item did not reach output");

endmodule

// File: rtl/core/glyph_alpha_blend_yuv422_unit.sv
// ----------------------------------------------------------------------------
// glyph_alpha_blend_yuv422_unit: white glyph overlay on a packed 4:2:2 frame
// Walks a glyph pair by pair, computes the frame word address, clips it and
// blends luma against the glyph alpha with chroma forced to mid gray.
//
//   channel  dir  handshake              payload
//   s_axis   in   tvalid/tready          tdata: alpha_left, alpha_right, bg
//   m_axis   out  tvalid/tready          tdata: address, word; tuser; tlast
//   cfg      in   cfg_valid/cfg_ready    cfg_index, cfg_data
//
// One pair per cycle sustained while the output is not stalled; a pair passes
// the queue register stage and then the two-stage multiply and blend pipeline
// on its way to the output. Reset restores the register defaults and the glyph origin.
// A stalled output holds the back pipeline; the four-entry queue keeps
// taking pairs until it fills. Configuration writes are taken every cycle.
// ----------------------------------------------------------------------------
module glyph_alpha_blend_yuv422_unit #(
  parameter int MAX_GLYPH_SIZE = gab_pkg::MaxGlyphSize,
  parameter int MAX_FRAME_SIZE = gab_pkg::MaxFrameSize
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // alpha_left[7:0], alpha_right[15:8], background_word[47:16]
  input  logic [47:0]                   s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // word_address[20:0], new_word[52:21], zero fill[55:53]
  output logic [55:0]                   m_axis_tdata,
  // write_enable[0]
  output logic                          m_axis_tuser,
  output logic                          m_axis_tlast,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [gab_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [gab_pkg::CfgDataW-1:0]  cfg_data_i
);
  import gab_pkg::*;

  logic [CfgColW-1:0]   col_origin_q;
  logic [CfgRowW-1:0]   row_origin_q;
  logic [CfgFrameW-1:0] frame_width_q, frame_height_q;
  logic [CfgGlyphW-1:0] glyph_width_q, glyph_height_q;
  logic [FSizeW-1:0]    fw_sat, fh_sat;
  gab_cfg_t             cfg;
  logic                 cfg_we;

  logic                 push_valid, push_ready, pop_valid, pop_ready;
  gab_item_t            push_item, pop_item;
  gab_result_t          result;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_origin_q   <= '0;
      row_origin_q   <= '0;
      frame_width_q  <= FrameWidthRst;
      frame_height_q <= FrameHeightRst;
      glyph_width_q  <= GlyphWidthRst;
      glyph_height_q <= GlyphHeightRst;
    end else if (cfg_we) begin
      unique case (cfg_index_i)
        RegColOrigin:   col_origin_q   <= cfg_data_i[CfgColW-1:0];
        RegRowOrigin:   row_origin_q   <= cfg_data_i[CfgRowW-1:0];
        RegFrameWidth:  frame_width_q  <= cfg_data_i[CfgFrameW-1:0];
        RegFrameHeight: frame_height_q <= cfg_data_i[CfgFrameW-1:0];
        RegGlyphWidth:  glyph_width_q  <= cfg_data_i[CfgGlyphW-1:0];
        RegGlyphHeight: glyph_height_q <= cfg_data_i[CfgGlyphW-1:0];
        default: ;
      endcase
    end
  end

  assign fw_sat = (FSizeW'(frame_width_q) > FSizeW'(MAX_FRAME_SIZE)) ?
                  FSizeW'(MAX_FRAME_SIZE) : FSizeW'(frame_width_q);
  assign fh_sat = (FSizeW'(frame_height_q) > FSizeW'(MAX_FRAME_SIZE)) ?
                  FSizeW'(MAX_FRAME_SIZE) : FSizeW'(frame_height_q);

  always_comb begin
    cfg.col_origin    = col_origin_q;
    cfg.row_origin    = row_origin_q;
    cfg.glyph_width   = glyph_width_q;
    cfg.glyph_height  = glyph_height_q;
    cfg.frame_height  = fh_sat;
    cfg.words_per_row = fw_sat[FSizeW-1:1];
  end

  gab_front #(
    .MAX_GLYPH_SIZE(MAX_GLYPH_SIZE)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .in_valid_i       (s_axis_tvalid),
    .in_ready_o       (s_axis_tready),
    .alpha_left_i     (s_axis_tdata[7:0]),
    .alpha_right_i    (s_axis_tdata[15:8]),
    .background_word_i(s_axis_tdata[47:16]),
    .push_valid_o     (push_valid),
    .push_ready_i     (push_ready),
    .push_item_o      (push_item)
  );

  gab_fifo #(
    .DEPTH(QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_item_i (push_item),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_item_o  (pop_item)
  );

  gab_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .words_per_row_i(cfg.words_per_row),
    .pop_valid_i    (pop_valid),
    .pop_ready_o    (pop_ready),
    .pop_item_i     (pop_item),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .result_o       (result)
  );

  assign m_axis_tdata = {3'b000, result.new_word, result.word_address};
  assign m_axis_tuser = result.write_enable;
  assign m_axis_tlast = result.glyph_done;

endmodule

// File: verif/tb_glyph_alpha_blend_yuv422_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_glyph_alpha_blend_yuv422_unit: self-checking bench for the glyph overlay
// Streams glyph alpha pairs with frame words through the unit under several
// register settings, and under random sender and receiver idling. It predicts
// each output word with its own model of the glyph walk, the clipping and the
// luma blend, then compares every output field in order.
// ----------------------------------------------------------------------------
module tb_glyph_alpha_blend_yuv422_unit;
  import gab_pkg::*;

  localparam int StallLimit   = 4000;
  localparam int ReportLimit  = 10;
  localparam int RandomPhases = 12;
  localparam int PhasePairs   = 107;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic m_axis_tuser;
  logic m_axis_tlast;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  logic [47:0] pending_pairs[$];
  gab_result_t expected_words[$];

  int unsigned send_idle_pct = 15;
  int unsigned recv_idle_pct = 82;
  int unsigned mismatches = 0;
  int unsigned words_checked = 0;
  int unsigned glyphs_done = 0;
  int unsigned words_untouched = 0;
  int unsigned settings_applied = 0;
  int unsigned stall_cycles = 0;

  logic [CfgColW-1:0] col_origin_q = '0;
  logic [CfgRowW-1:0] row_origin_q = '0;
  logic [CfgFrameW-1:0] frame_width_q = FrameWidthRst;
  logic [CfgFrameW-1:0] frame_height_q = FrameHeightRst;
  logic [CfgGlyphW-1:0] glyph_width_q = GlyphWidthRst;
  logic [CfgGlyphW-1:0] glyph_height_q = GlyphHeightRst;
  logic [4:0] pair_col_q = '0;
  logic [5:0] glyph_row_q = '0;

  glyph_alpha_blend_yuv422_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic logic [7:0] lighten(logic [7:0] alpha, logic [7:0] luma);
    int unsigned av, lv;
    av = alpha;
    lv = luma;
    return 8'(av + ((255 - av) * lv) / 255);
  endfunction

  function automatic gab_result_t overlay_pair(logic [7:0] al, logic [7:0] ar,
                                               logic [31:0] bg);
    gab_result_t res;
    int unsigned gw, gh, fw, fh, wpr, pairs, row, col;
    logic tail, in_frame;
    logic [7:0] y0, y1;
    gw = (glyph_width_q == 0) ? 1 :
         (glyph_width_q > MaxGlyphSize) ? MaxGlyphSize : glyph_width_q;
    gh = (glyph_height_q == 0) ? 1 :
         (glyph_height_q > MaxGlyphSize) ? MaxGlyphSize : glyph_height_q;
    fw = (frame_width_q > MaxFrameSize) ? MaxFrameSize : frame_width_q;
    fh = (frame_height_q > MaxFrameSize) ? MaxFrameSize : frame_height_q;
    wpr = fw / 2;
    pairs = (gw + 1) / 2;
    row = row_origin_q + glyph_row_q;
    col = col_origin_q + pair_col_q;
    tail = (2 * pair_col_q + 1) >= gw;
    in_frame = (row < fh) && (col < wpr);
    if (tail) ar = '0;
    res.word_address = '0;
    res.new_word = bg;
    res.write_enable = 1'b0;
    res.glyph_done = 1'b0;
    if (in_frame) begin
      res.word_address = AddrW'(row * wpr + col);
      if (al != 0 || ar != 0) begin
        y0 = lighten(al, bg[15:8]);
        y1 = tail ? bg[31:24] : lighten(ar, bg[31:24]);
        res.new_word = {y1, ChromaFill, y0, ChromaFill};
        res.write_enable = 1'b1;
      end
    end
    if (pair_col_q + 1 >= pairs) begin
      pair_col_q = '0;
      if (glyph_row_q + 1 >= gh) begin
        glyph_row_q = '0;
        res.glyph_done = 1'b1;
      end else begin
        glyph_row_q = glyph_row_q + 1'b1;
      end
    end else begin
      pair_col_q = pair_col_q + 1'b1;
    end
    return res;
  endfunction

  // Driver: hold the pair until taken, predict on every accepted transaction.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_words.push_back(overlay_pair(s_axis_tdata[7:0], s_axis_tdata[15:8],
                                              s_axis_tdata[47:16]));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_pairs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= pending_pairs.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each output transaction with the oldest prediction.
  always @(posedge clk_i) begin
    gab_result_t exp_w;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_words.size() == 0) begin
          mismatches++;
          if (mismatches <= ReportLimit)
            $display("unexpected output: addr %h word %h we %b done %b",
                     m_axis_tdata[20:0], m_axis_tdata[52:21], m_axis_tuser,
                     m_axis_tlast);
        end else begin
          exp_w = expected_words.pop_front();
          words_checked++;
          if (exp_w.glyph_done) glyphs_done++;
          if (!exp_w.write_enable) words_untouched++;
          if (m_axis_tdata[20:0] !== exp_w.word_address ||
              m_axis_tdata[52:21] !== exp_w.new_word ||
              m_axis_tuser !== exp_w.write_enable ||
              m_axis_tlast !== exp_w.glyph_done) begin
            mismatches++;
            if (mismatches <= ReportLimit)
              $display({"mismatch at word %0d: exp addr %h word %h we %b done %b,",
                        " got addr %h word %h we %b done %b"},
                       words_checked, exp_w.word_address, exp_w.new_word,
                       exp_w.write_enable, exp_w.glyph_done, m_axis_tdata[20:0],
                       m_axis_tdata[52:21], m_axis_tuser, m_axis_tlast);
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
        $display("no transaction for %0d cycles", StallLimit);
        $display("tb_glyph_alpha_blend_yuv422_unit failed");
        $finish;
      end
    end
  end

  task automatic push_pair(logic [7:0] al, logic [7:0] ar, logic [31:0] bg);
    pending_pairs.push_back({bg, ar, al});
  endtask

  task automatic wait_drained();
    while (pending_pairs.size() != 0 || s_axis_tvalid || expected_words.size() != 0)
      @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic cfg_write(gab_reg_e idx, int unsigned value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= CfgDataW'(value);
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      RegColOrigin:   col_origin_q = CfgColW'(value);
      RegRowOrigin:   row_origin_q = CfgRowW'(value);
      RegFrameWidth:  frame_width_q = CfgFrameW'(value);
      RegFrameHeight: frame_height_q = CfgFrameW'(value);
      RegGlyphWidth:  glyph_width_q = CfgGlyphW'(value);
      RegGlyphHeight: glyph_height_q = CfgGlyphW'(value);
      default: ;
    endcase
  endtask

  task automatic apply_setup(int unsigned co, int unsigned ro, int unsigned fw,
                             int unsigned fh, int unsigned gw, int unsigned gh);
    cfg_write(RegColOrigin, co);
    cfg_write(RegRowOrigin, ro);
    cfg_write(RegFrameWidth, fw);
    cfg_write(RegFrameHeight, fh);
    cfg_write(RegGlyphWidth, gw);
    cfg_write(RegGlyphHeight, gh);
    cfg_valid_i <= 1'b0;
    settings_applied++;
  endtask

  initial begin
    logic [7:0] dir_al [7] = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h01, 8'h80, 8'h00};
    logic [7:0] dir_ar [7] = '{8'h00, 8'hFF, 8'hFF, 8'h00, 8'hFE, 8'h7F, 8'h00};
    logic [31:0] dir_bg [3] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hA5C3_5A3C};
    int unsigned fw, fh, gw, gh, co, ro, wpr, pairs, base, pick;
    logic near_edge;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset register values
    push_pair(8'h00, 8'h00, 32'hFFFF_FFFF);
    push_pair(8'hFF, 8'hFF, 32'h0000_0000);
    push_pair(8'h80, 8'h01, 32'h1234_5678);
    wait_drained();

    // odd glyph straddling right and bottom frame edges, counters past new size
    apply_setup(8, 8, 20, 10, 5, 3);
    @(negedge clk_i);
    for (int i = 0; i < 16; i++) push_pair(dir_al[i % 7], dir_ar[i % 7], dir_bg[i % 3]);
    wait_drained();

    // zero glyph sizes, frame narrower than one word
    apply_setup(0, 0, 1, 480, 0, 0);
    @(negedge clk_i);
    push_pair(8'hFF, 8'hFF, 32'h0000_0000);
    push_pair(8'h40, 8'h00, 32'hFFFF_FFFF);
    wait_drained();

    // oversized registers saturate; glyph at the far corner
    apply_setup(1023, 2047, 4095, 4095, 127, 127);
    @(negedge clk_i);
    push_pair(8'hFF, 8'hFF, 32'hFFFF_FFFF);
    push_pair(8'h00, 8'h4D, 32'h0000_0000);
    wait_drained();

    for (int p = 0; p < RandomPhases; p++) begin
      if (p < RandomPhases / 3) begin
        send_idle_pct = 15;
        recv_idle_pct = 82;
      end else if (p < 2 * RandomPhases / 3) begin
        send_idle_pct = 82;
        recv_idle_pct = 15;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      near_edge = 1'b1;
      fw = $urandom_range(0, 1) ? $urandom_range(2, 96) : $urandom_range(2, 2048);
      fh = $urandom_range(0, 1) ? $urandom_range(1, 40) : $urandom_range(1, 2048);
      gw = $urandom_range(1, 16);
      gh = $urandom_range(1, 10);
      case (p)
        2: begin
          fw = 2048;
          fh = 2048;
          co = 1023;
          ro = 2047;
          near_edge = 1'b0;
        end
        5: begin
          fw = 2;
          fh = 1;
          co = 0;
          ro = 0;
          near_edge = 1'b0;
        end
        7: begin
          gw = 64;
          gh = 64;
        end
        9: begin
          fw = $urandom_range(2049, 4095);
          fh = $urandom_range(2049, 4095);
          gw = $urandom_range(65, 127);
          gh = $urandom_range(1, 4);
        end
        default: ;
      endcase
      if (near_edge) begin
        wpr = ((fw > MaxFrameSize) ? MaxFrameSize : fw) / 2;
        pairs = (((gw > MaxGlyphSize) ? MaxGlyphSize : gw) + 1) / 2;
        base = (wpr > pairs) ? wpr - pairs : 0;
        co = base + $urandom_range(0, pairs);
        if (co > 1023 || $urandom_range(0, 4) == 0) co = $urandom_range(0, 1023);
        base = (fh > gh) ? fh - gh : 0;
        ro = base + $urandom_range(0, gh);
        if (ro > 2047 || $urandom_range(0, 4) == 0) ro = $urandom_range(0, 2047);
      end
      apply_setup(co, ro, fw, fh, gw, gh);
      @(negedge clk_i);
      for (int i = 0; i < PhasePairs; i++) begin
        pick = $urandom_range(0, 9);
        case (pick)
          0, 1, 2: push_pair(8'h00, 8'h00, $urandom);
          3:       push_pair(8'hFF, 8'hFF, $urandom);
          4:       push_pair(8'h00, 8'($urandom), $urandom);
          5:       push_pair(8'($urandom), 8'h00, $urandom);
          default: push_pair(8'($urandom), 8'($urandom), $urandom);
        endcase
      end
      wait_drained();
    end

    wait_drained();
    $display("checked %0d output words under %0d register settings", words_checked,
             settings_applied);
    $display("%0d glyphs completed, %0d words clipped or left untouched, %0d mismatches",
             glyphs_done, words_untouched, mismatches);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("tb_glyph_alpha_blend_yuv422_unit passed");
    end else begin
      $display("tb_glyph_alpha_blend_yuv422_unit failed");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/gab_pkg.sv
rtl/core/gab_front.sv
rtl/core/gab_fifo.sv
rtl/core/gab_back.sv
rtl/core/glyph_alpha_blend_yuv422_unit.sv
verif/tb_glyph_alpha_blend_yuv422_unit.sv
